// File: hw/rtl/rfo_pkg.sv
package rfo_pkg;

    localparam int unsigned CMD_W         = 2;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned FILL_W        = 8;
    localparam int unsigned RESULT_W      = 32;
    localparam int unsigned DEPTH_DEFAULT = 256;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam cmd_t CMD_PUSH  = 2'd0;
    localparam cmd_t CMD_POP   = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

    // Result word, lowest field last
    typedef struct packed {
        logic [4:0]        pad;
        byte_t             head_byte;
        logic              head_valid;
        logic [FILL_W-1:0] fill_count;
        logic              overwrote;
        byte_t             pop_byte;
        logic              pop_valid;
    } result_t;

endpackage

// File: hw/rtl/rfo_ram.sv
module rfo_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same address is written
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: hw/rtl/rx_ring_fifo_overwrite_oldest_unit.sv
// A transaction is captured in the input register, then its result in the result register,
// which drives m_tvalid; a stalled output (m_tvalid high, m_tready low) holds the input
// register. Throughput is one transaction per cycle while the output is not stalled,
// set by the single update step between the two registers and the two RAM read ports
// that keep the head byte and the byte after it ready every cycle.
// Reset (aresetn low, synchronous) empties the buffer: indexes and count go to zero.
// The byte store itself is not cleared; only written slots are ever read.
module rx_ring_fifo_overwrite_oldest_unit #(
    parameter int unsigned DEPTH = rfo_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rfo_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    input  logic [rfo_pkg::CMD_W-1:0]     s_tuser,   // [1:0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rfo_pkg::RESULT_W-1:0]  m_tdata    // [0] pop_valid, [8:1] pop_byte,
                                                     // [9] overwrote, [17:10] fill_count,
                                                     // [18] head_valid, [26:19] head_byte,
                                                     // [31:27] zero
);

    import rfo_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + AW'(1);
    endfunction

    logic          in_valid_reg;
    cmd_t          cmd_reg;
    byte_t         byte_reg;
    logic          out_valid_reg;
    result_t       result_reg;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] count_reg, count_next;
    logic          byp0_reg, byp1_reg;
    byte_t         byp_byte_reg;

    logic          advance;
    logic          wr_en;
    logic          rd_advanced;
    logic [AW-1:0] rd_addr1;
    byte_t         rd_data0, rd_data1;
    byte_t         head0_now, head1_now, new_head;
    result_t       result_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // Current head and the byte after it, patched with a write from last cycle
    assign head0_now = byp0_reg ? byp_byte_reg : rd_data0;
    assign head1_now = byp1_reg ? byp_byte_reg : rd_data1;

    always_comb begin
        rd_idx_next             = rd_idx_reg;
        wr_idx_next             = wr_idx_reg;
        count_next              = count_reg;
        wr_en                   = 1'b0;
        rd_advanced             = 1'b0;
        result_next             = '0;
        if (advance) begin
            unique case (cmd_reg)
                CMD_PUSH: begin
                    if (count_reg != LAST_SLOT) begin
                        count_next = count_reg + AW'(1);
                    end else begin
                        // Full: drop the oldest byte
                        rd_idx_next           = next_slot(rd_idx_reg);
                        rd_advanced           = 1'b1;
                        result_next.overwrote = 1'b1;
                    end
                    wr_en       = 1'b1;
                    wr_idx_next = next_slot(wr_idx_reg);
                end
                CMD_POP: begin
                    if (count_reg != '0) begin
                        result_next.pop_valid = 1'b1;
                        result_next.pop_byte  = head0_now;
                        rd_idx_next           = next_slot(rd_idx_reg);
                        rd_advanced           = 1'b1;
                        count_next            = count_reg - AW'(1);
                    end
                end
                CMD_CLEAR: begin
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    count_next  = '0;
                end
                default: begin
                end
            endcase
        end

        if (wr_en && (wr_idx_reg == rd_idx_next)) begin
            new_head = byte_reg;
        end else if (rd_advanced) begin
            new_head = head1_now;
        end else begin
            new_head = head0_now;
        end

        result_next.fill_count = FILL_W'(count_next);
        result_next.head_valid = (count_next != '0);
        result_next.head_byte  = (count_next != '0) ? new_head : '0;
    end

    assign rd_addr1 = next_slot(rd_idx_next);

    rfo_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_idx_reg),
        .wr_data   (byte_reg),
        .rd_addr_a (rd_idx_next),
        .rd_addr_b (rd_addr1),
        .rd_data_a (rd_data0),
        .rd_data_b (rd_data1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            count_reg     <= '0;
            byp0_reg      <= 1'b0;
            byp1_reg      <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            count_reg  <= count_next;
            byp0_reg   <= wr_en && (wr_idx_reg == rd_idx_next);
            byp1_reg   <= wr_en && (wr_idx_reg == rd_addr1);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg  <= s_tuser;
            byte_reg <= s_tdata;
        end
        if (advance) begin
            result_reg <= result_next;
        end
        byp_byte_reg <= byte_reg;
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rfo_pkg::*;

    localparam int unsigned DEPTH       = DEPTH_DEFAULT;
    localparam int unsigned HALF_PERIOD = 6;
    localparam int unsigned RUN_CMDS    = 1800;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam cmd_t        CMD_RESERVED = 2'd3;

    typedef struct {
        cmd_t        cmd;
        byte_t       rx;
        int unsigned gap;
    } rx_cmd_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata  = '0;   // [7:0] rx_byte
    logic [CMD_W-1:0]    s_tuser  = '0;   // [1:0] cmd
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RESULT_W-1:0] m_tdata;         // [0] pop_valid, [8:1] pop_byte, [9] overwrote,
                                          // [17:10] fill_count, [18] head_valid,
                                          // [26:19] head_byte, [31:27] zero
    logic                hold_off = 1'b0;

    rx_cmd_t     rx_cmds_pending[$];
    result_t     due_results[$];
    int unsigned cmds_accepted = 0;
    int unsigned results_seen  = 0;
    int unsigned err_count     = 0;

    // Ring model state
    byte_t       ring_mem [DEPTH];
    int unsigned rd_ptr = 0;
    int unsigned wr_ptr = 0;
    int unsigned held   = 0;

    rx_ring_fifo_overwrite_oldest_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    function automatic result_t ring_step(cmd_t cmd, byte_t rx);
        result_t r;
        r = '0;
        case (cmd)
            CMD_PUSH: begin
                if (held < DEPTH - 1) begin
                    held++;
                end else begin
                    // full: drop the oldest byte, count stays
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    r.overwrote = 1'b1;
                end
                ring_mem[wr_ptr] = rx;
                wr_ptr = (wr_ptr + 1) % DEPTH;
            end
            CMD_POP: begin
                if (held != 0) begin
                    r.pop_valid = 1'b1;
                    r.pop_byte  = ring_mem[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    held--;
                end
            end
            CMD_CLEAR: begin
                rd_ptr = 0;
                wr_ptr = 0;
                held   = 0;
            end
            default: ;
        endcase
        r.fill_count = FILL_W'(held);
        r.head_valid = (held != 0);
        r.head_byte  = (held != 0) ? ring_mem[rd_ptr] : '0;
        return r;
    endfunction

    function automatic int unsigned pick_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic queue_cmd(cmd_t cmd, byte_t rx, int unsigned gap);
        rx_cmd_t c;
        c.cmd = cmd;
        c.rx  = rx;
        c.gap = gap;
        rx_cmds_pending.push_back(c);
    endtask

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        $display("tb_top: mismatch on %s in result %0d: got 0x%0h, want 0x%0h",
                 what, results_seen, got, want);
        err_count++;
    endtask

    // Driver: offer queued transactions, predict on acceptance
    int unsigned gap_count = 0;
    always @(posedge aclk) begin
        rx_cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_results.push_back(ring_step(s_tuser, s_tdata));
                cmds_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (rx_cmds_pending.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (gap_count < rx_cmds_pending[0].gap) begin
                    gap_count++;
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = rx_cmds_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.rx;
                    s_tuser  <= nxt.cmd;
                    gap_count = 0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    int unsigned stall_left  = 0;
    int unsigned mode_left   = 0;
    bit          sink_steady = 1'b0;
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (due_results.size() == 0) begin
                    flag_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    want = due_results.pop_front();
                    if (got.pop_valid !== want.pop_valid)
                        flag_mismatch("pop_valid", got.pop_valid, want.pop_valid);
                    if (got.pop_byte !== want.pop_byte)
                        flag_mismatch("pop_byte", got.pop_byte, want.pop_byte);
                    if (got.overwrote !== want.overwrote)
                        flag_mismatch("overwrote", got.overwrote, want.overwrote);
                    if (got.fill_count !== want.fill_count)
                        flag_mismatch("fill_count", got.fill_count, want.fill_count);
                    if (got.head_valid !== want.head_valid)
                        flag_mismatch("head_valid", got.head_valid, want.head_valid);
                    if (got.head_byte !== want.head_byte)
                        flag_mismatch("head_byte", got.head_byte, want.head_byte);
                end
                results_seen++;
                if (mode_left == 0) begin
                    sink_steady = ($urandom_range(0, 3) == 0);
                    mode_left   = $urandom_range(20, 150);
                end else begin
                    mode_left--;
                end
                stall_left = pick_gap(sink_steady);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= !hold_off && (stall_left == 0);
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial begin
        int unsigned marks [2];
        marks[0] = 600;
        marks[1] = 1400;
        wait (aresetn);
        foreach (marks[i]) begin
            wait (cmds_accepted >= marks[i]);
            @(posedge aclk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_off <= 1'b0;
        end
    end

    initial begin
        #(2 * HALF_PERIOD * 400000);
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        int unsigned n_run;
        int unsigned len;
        int unsigned pick;
        bit          steady;
        cmd_t        c;

        // Directed: byte extremes, every command, empty pop, reserved code, clear
        queue_cmd(CMD_POP,      8'h00, 0);
        queue_cmd(CMD_PUSH,     8'h00, 0);
        queue_cmd(CMD_PUSH,     8'hFF, 1);
        queue_cmd(CMD_PUSH,     8'hA5, 0);
        queue_cmd(CMD_PUSH,     8'h5A, 2);
        queue_cmd(CMD_POP,      8'hFF, 0);
        queue_cmd(CMD_POP,      8'h00, 0);
        queue_cmd(CMD_RESERVED, 8'hFF, 0);
        queue_cmd(CMD_RESERVED, 8'h00, 3);
        queue_cmd(CMD_POP,      8'h00, 0);
        queue_cmd(CMD_POP,      8'h00, 0);
        queue_cmd(CMD_POP,      8'h00, 1);
        queue_cmd(CMD_POP,      8'hFF, 0);
        queue_cmd(CMD_PUSH,     8'h80, 0);
        queue_cmd(CMD_PUSH,     8'h01, 0);
        queue_cmd(CMD_CLEAR,    8'hFF, 0);
        queue_cmd(CMD_POP,      8'h00, 0);
        queue_cmd(CMD_PUSH,     8'h7F, 4);
        queue_cmd(CMD_RESERVED, 8'h7F, 0);
        queue_cmd(CMD_POP,      8'h00, 0);
        queue_cmd(CMD_CLEAR,    8'h00, 0);
        queue_cmd(CMD_CLEAR,    8'h00, 0);
        queue_cmd(CMD_PUSH,     8'hFE, 6);

        // Random phases: long fills that reach full and overwrite, drains, mixed traffic
        n_run = 0;
        while (n_run < RUN_CMDS) begin
            steady = ($urandom_range(0, 3) == 0);
            pick   = $urandom_range(0, 9);
            if (pick <= 2) begin
                len = $urandom_range(240, 300);
                repeat (len) begin
                    c = ($urandom_range(0, 15) == 0) ? CMD_POP : CMD_PUSH;
                    queue_cmd(c, byte_t'($urandom), pick_gap(steady));
                end
                n_run += len;
            end else if (pick <= 4) begin
                len = $urandom_range(5, 260);
                repeat (len) queue_cmd(CMD_POP, byte_t'($urandom), pick_gap(steady));
                n_run += len;
            end else if (pick <= 7) begin
                len = $urandom_range(20, 80);
                repeat (len) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45)      c = CMD_PUSH;
                    else if (pick < 85) c = CMD_POP;
                    else if (pick < 90) c = CMD_CLEAR;
                    else                c = CMD_RESERVED;
                    queue_cmd(c, byte_t'($urandom), pick_gap(steady));
                    if (c != CMD_RESERVED) n_run++;
                end
            end else if (pick == 8) begin
                queue_cmd(CMD_CLEAR, byte_t'($urandom), pick_gap(steady));
                n_run++;
            end else begin
                repeat ($urandom_range(1, 3))
                    queue_cmd(CMD_RESERVED, byte_t'($urandom), pick_gap(steady));
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        wait (rx_cmds_pending.size() == 0 && !s_tvalid && due_results.size() == 0);
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
